[hw/rtl/shfp_pkg.sv]
`default_nettype none

package shfp_pkg;

  // Frame layout
  localparam int DataBytes = 36;
  localparam int WordCount = DataBytes / 4;
  localparam int IdxW      = 6;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 8;

  localparam logic [IdxW-1:0] LastDataIdx = IdxW'(DataBytes);

  // Register reset values and indexes
  localparam logic [7:0] FirstSyncReset  = 8'hFE;
  localparam logic [7:0] SecondSyncReset = 8'h22;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_SYNC  = 1'b0,
    CFG_SECOND_SYNC = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  // One finished frame as handed from the parser to the output stage
  typedef struct packed {
    logic signed [31:0] lat_whole;
    logic signed [31:0] lat_fraction;
    logic signed [31:0] lon_whole;
    logic signed [31:0] lon_fraction;
    logic signed [31:0] east_position;
    logic signed [31:0] north_position;
    logic signed [31:0] east_velocity;
    logic signed [31:0] north_velocity;
    logic signed [31:0] heading;
    logic               sum_ok;
  } result_t;

  // Parser to output stage control
  typedef struct packed {
    logic load;
    logic slot_free;
  } out_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/shfp_byte_if.sv]
`default_nettype none

interface shfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/shfp_frame_if.sv]
`default_nettype none

interface shfp_frame_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lat_whole;
  logic signed [31:0] lat_fraction;
  logic signed [31:0] lon_whole;
  logic signed [31:0] lon_fraction;
  logic signed [31:0] east_position;
  logic signed [31:0] north_position;
  logic signed [31:0] east_velocity;
  logic signed [31:0] north_velocity;
  logic signed [31:0] heading;
  logic               sum_ok;

  modport source (
    output valid, input ready,
    output lat_whole, output lat_fraction, output lon_whole, output lon_fraction,
    output east_position, output north_position, output east_velocity,
    output north_velocity, output heading, output sum_ok
  );
  modport sink (
    input valid, output ready,
    input lat_whole, input lat_fraction, input lon_whole, input lon_fraction,
    input east_position, input north_position, input east_velocity,
    input north_velocity, input heading, input sum_ok
  );
endinterface

`default_nettype wire

[hw/rtl/shfp_parser.sv]
`default_nettype none

module shfp_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  shfp_byte_if.sink                            in_ch,
  input  wire logic                            cfg_we,
  input  wire logic [shfp_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [shfp_pkg::CfgDataW-1:0]   cfg_data,
  input  wire logic                            slot_free,
  output shfp_pkg::out_ctl_t                   ctl,
  output shfp_pkg::result_t                    result
);
  import shfp_pkg::*;

  phase_t          phase, phase_next;
  logic [IdxW-1:0] byte_index, byte_index_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [7:0]      check_byte;
  logic [7:0]      first_sync, second_sync;
  logic [7:0]      data_sr [DataBytes];
  logic            beat;
  logic            store_data;
  logic            store_check;
  logic [31:0]     words [WordCount];

  // Hold off only a trailer beat while the output slot is still occupied
  assign in_ch.ready = slot_free || (phase != PH_TRAILER);
  assign beat        = in_ch.valid && in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FirstSyncReset;
      second_sync <= SecondSyncReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        CFG_SECOND_SYNC: second_sync <= cfg_data;
        default: ;
      endcase
    end
  end

  // Phase sequencing
  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    store_data       = 1'b0;
    store_check      = 1'b0;
    ctl.load         = 1'b0;
    ctl.slot_free    = slot_free;
    if (beat) begin
      unique case (phase)
        PH_HUNT: begin
          if (in_ch.rx_byte == first_sync) phase_next = PH_SECOND;
        end
        PH_SECOND: begin
          if (in_ch.rx_byte == second_sync) begin
            phase_next       = PH_PAYLOAD;
            byte_index_next  = '0;
            running_sum_next = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (byte_index < LastDataIdx) begin
            store_data       = 1'b1;
            running_sum_next = running_sum + in_ch.rx_byte;
            byte_index_next  = byte_index + IdxW'(1);
          end else begin
            store_check     = 1'b1;
            byte_index_next = '0;
            phase_next      = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          ctl.load        = 1'b1;
          phase_next      = PH_HUNT;
          byte_index_next = '0;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_index  <= '0;
      running_sum <= '0;
    end else begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  // Data bytes shift in at the top; after a full frame entry 0 holds byte 0
  always_ff @(posedge clk) begin
    if (store_data) begin
      for (int i = 0; i < DataBytes - 1; i++) data_sr[i] <= data_sr[i+1];
      data_sr[DataBytes-1] <= in_ch.rx_byte;
    end
    if (store_check) check_byte <= in_ch.rx_byte;
  end

  // Big-endian words from the stored bytes
  always_comb begin
    for (int k = 0; k < WordCount; k++) begin
      words[k] = {data_sr[4*k], data_sr[4*k+1], data_sr[4*k+2], data_sr[4*k+3]};
    end
  end

  assign result.lat_whole      = words[0];
  assign result.lat_fraction   = words[1];
  assign result.lon_whole      = words[2];
  assign result.lon_fraction   = words[3];
  assign result.east_position  = words[4];
  assign result.north_position = words[5];
  assign result.east_velocity  = words[6];
  assign result.north_velocity = words[7];
  assign result.heading        = words[8];
  assign result.sum_ok         = (running_sum == check_byte);

endmodule

`default_nettype wire

[hw/rtl/shfp_out_reg.sv]
`default_nettype none

module shfp_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire shfp_pkg::out_ctl_t ctl,
  input  wire shfp_pkg::result_t  result,
  output logic                    slot_free,
  shfp_frame_if.source            out_ch
);
  import shfp_pkg::*;

  logic    out_valid;
  result_t held;

  assign slot_free = !out_valid || out_ch.ready;

  // Valid flag: set on a finished frame, cleared once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.load && ctl.slot_free) held <= result;
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.lat_whole      = held.lat_whole;
  assign out_ch.lat_fraction   = held.lat_fraction;
  assign out_ch.lon_whole      = held.lon_whole;
  assign out_ch.lon_fraction   = held.lon_fraction;
  assign out_ch.east_position  = held.east_position;
  assign out_ch.north_position = held.north_position;
  assign out_ch.east_velocity  = held.east_velocity;
  assign out_ch.north_velocity = held.north_velocity;
  assign out_ch.heading        = held.heading;
  assign out_ch.sum_ok         = held.sum_ok;

endmodule

`default_nettype wire

[hw/rtl/sync_header_frame_parser_with_sum_check_top.sv]
// A frame result becomes valid in the cycle after its trailer byte is accepted.
// Throughput: one received byte per cycle; the trailer byte waits only while
// the previous result still sits unaccepted in the output register.
// Reset (rst, synchronous): parser returns to hunting, sum and index clear,
// sync registers return to 0xFE and 0x22, output register empties.
`default_nettype none

module sync_header_frame_parser_with_sum_check_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  shfp_byte_if.sink                          in_ch,
  shfp_frame_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [shfp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [shfp_pkg::CfgDataW-1:0] cfg_data
);
  import shfp_pkg::*;

  out_ctl_t ctl;
  result_t  result;
  logic     slot_free;

  shfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .slot_free (slot_free),
    .ctl       (ctl),
    .result    (result)
  );

  shfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .result    (result),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[tb/sv/shfp_frame_checker.sv]
`timescale 1ns / 1ps

module shfp_frame_checker (
  input  logic                          clk,
  input  logic                          rst,
  shfp_byte_if                          byte_ch,
  shfp_frame_if                         frame_ch,
  input  logic                          cfg_we,
  input  logic [shfp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [shfp_pkg::CfgDataW-1:0] cfg_data,
  output int                            errors,
  output int                            frames_pending,
  output int                            frames_checked,
  output int                            bad_sum_frames
);
  import shfp_pkg::*;

  // Parser mirror
  phase_t     parse_phase;
  logic [5:0] byte_idx;
  logic [7:0] data_bytes [DataBytes];
  logic [7:0] running_sum;
  logic [7:0] check_byte;
  logic [7:0] first_sync;
  logic [7:0] second_sync;

  // Frames predicted but not yet seen on the output
  result_t frames_due [$];

  int mismatch_count = 0;
  int checked_count  = 0;
  int bad_sum_count  = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [31:0] payload_word(input int k);
    return {data_bytes[4*k], data_bytes[4*k+1], data_bytes[4*k+2], data_bytes[4*k+3]};
  endfunction

  // Advance the mirror by one accepted byte; a trailer yields a frame
  task automatic parse_byte(input logic [7:0] b);
    result_t frame;
    case (parse_phase)
      PH_HUNT: begin
        if (b == first_sync) parse_phase = PH_SECOND;
      end
      PH_SECOND: begin
        // a wrong byte here is dropped, not retried as a first sync
        if (b == second_sync) begin
          parse_phase = PH_PAYLOAD;
          byte_idx    = '0;
          running_sum = '0;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (byte_idx < LastDataIdx) begin
          data_bytes[byte_idx] = b;
          running_sum          = running_sum + b;
          byte_idx             = byte_idx + 6'd1;
        end else begin
          check_byte  = b;
          byte_idx    = '0;
          parse_phase = PH_TRAILER;
        end
      end
      default: begin
        // trailer value is ignored
        frame.lat_whole      = payload_word(0);
        frame.lat_fraction   = payload_word(1);
        frame.lon_whole      = payload_word(2);
        frame.lon_fraction   = payload_word(3);
        frame.east_position  = payload_word(4);
        frame.north_position = payload_word(5);
        frame.east_velocity  = payload_word(6);
        frame.north_velocity = payload_word(7);
        frame.heading        = payload_word(8);
        frame.sum_ok         = (running_sum == check_byte);
        frames_due.push_back(frame);
        parse_phase = PH_HUNT;
        byte_idx    = '0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %h, predicted %h", name, got, want));
  endtask

  // Compare one output beat against the oldest prediction
  task automatic check_frame();
    result_t want;
    if (frames_due.size() == 0) begin
      report($sformatf("frame beat with none due (lat_whole %h)", frame_ch.lat_whole));
      return;
    end
    want = frames_due.pop_front();
    check_field("lat_whole", frame_ch.lat_whole, want.lat_whole);
    check_field("lat_fraction", frame_ch.lat_fraction, want.lat_fraction);
    check_field("lon_whole", frame_ch.lon_whole, want.lon_whole);
    check_field("lon_fraction", frame_ch.lon_fraction, want.lon_fraction);
    check_field("east_position", frame_ch.east_position, want.east_position);
    check_field("north_position", frame_ch.north_position, want.north_position);
    check_field("east_velocity", frame_ch.east_velocity, want.east_velocity);
    check_field("north_velocity", frame_ch.north_velocity, want.north_velocity);
    check_field("heading", frame_ch.heading, want.heading);
    check_field("sum_ok", 32'(frame_ch.sum_ok), 32'(want.sum_ok));
    checked_count++;
    if (!want.sum_ok) bad_sum_count++;
  endtask

  // Sample both channels and the register port at each edge
  always @(posedge clk) begin
    if (rst) begin
      parse_phase = PH_HUNT;
      byte_idx    = '0;
      running_sum = '0;
      first_sync  = FirstSyncReset;
      second_sync = SecondSyncReset;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_SYNC) first_sync = cfg_data;
        else second_sync = cfg_data;
      end
      if (frame_ch.valid && frame_ch.ready) check_frame();
      if (byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.rx_byte);
    end
    frames_pending <= frames_due.size();
    errors         <= mismatch_count;
    frames_checked <= checked_count;
    bad_sum_frames <= bad_sum_count;
  end

endmodule

[tb/sv/sync_header_frame_parser_with_sum_check_top_tb.sv]
`timescale 1ns / 1ps

module sync_header_frame_parser_with_sum_check_top_tb;
  import shfp_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  shfp_byte_if  byte_ch ();
  shfp_frame_if frame_ch ();

  int errors;
  int frames_pending;
  int frames_checked;
  int bad_sum_frames;

  // Stimulus state
  int          send_idle_pct;
  int          recv_idle_pct;
  int          bytes_sent;
  int          sync_settings;
  logic [7:0]  cur_first;
  logic [7:0]  cur_second;
  logic [31:0] frame_words [WordCount];

  sync_header_frame_parser_with_sum_check_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (byte_ch),
    .out_ch    (frame_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  shfp_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_ch        (byte_ch),
    .frame_ch       (frame_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked),
    .bad_sum_frames (bad_sum_frames)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit
  initial begin
    #20ms;
    $display("sync_header_frame_parser_with_sum_check_top test failed");
    $finish;
  end

  // One byte beat; valid stays high across back-to-back beats
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off the sender until every predicted frame has come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_syncs(input logic [7:0] fs, input logic [7:0] ss);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_SYNC;
    cfg_data  <= fs;
    @(posedge clk);
    cfg_index <= CFG_SECOND_SYNC;
    cfg_data  <= ss;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_first  = fs;
    cur_second = ss;
    sync_settings++;
  endtask

  // Header, frame_words as big-endian data, check byte, random trailer
  task automatic send_frame(input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    send_byte(cur_first);
    send_byte(cur_second);
    for (int k = 0; k < DataBytes; k++) begin
      b   = frame_words[k / 4][31 - 8 * (k % 4) -: 8];
      sum = sum + b;
      send_byte(b);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
    send_byte(8'($urandom));
  endtask

  // Mostly well-formed frames, with noise, bad headers and cut-off frames
  task automatic run_block(input int min_bytes, input int min_frames);
    int         start_bytes;
    int         start_frames;
    int         pick;
    logic [7:0] wrong;
    start_bytes  = bytes_sent;
    start_frames = frames_checked;
    while (bytes_sent - start_bytes < min_bytes || frames_checked - start_frames < min_frames) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        for (int w = 0; w < WordCount; w++) begin
          case ($urandom_range(9))
            0:       frame_words[w] = 32'h8000_0000;
            1:       frame_words[w] = 32'h7FFF_FFFF;
            2:       frame_words[w] = 32'h0000_0000;
            3:       frame_words[w] = 32'hFFFF_FFFF;
            4:       frame_words[w] = {cur_first, cur_second, cur_first, cur_second};
            default: frame_words[w] = $urandom;
          endcase
        end
        send_frame($urandom_range(3) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (pick < 88) begin
        // header broken at the second byte, sometimes by a repeated first sync
        if ($urandom_range(1) == 0 && cur_first != cur_second) begin
          wrong = cur_first;
        end else begin
          wrong = 8'($urandom);
          while (wrong == cur_second) wrong = 8'($urandom);
        end
        send_byte(cur_first);
        send_byte(wrong);
      end else if (pick < 96) begin
        // good header, frame cut short; following bytes land in its payload
        send_byte(cur_first);
        send_byte(cur_second);
        repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_FIRST_SYNC;
    cfg_data         = '0;
    byte_ch.valid    = 1'b0;
    byte_ch.rx_byte  = '0;
    send_idle_pct    = 24;
    recv_idle_pct    = 77;
    bytes_sent       = 0;
    sync_settings    = 1;
    cur_first        = FirstSyncReset;
    cur_second       = SecondSyncReset;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, lone second sync, repeated first sync as second byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_second);
    send_byte(cur_first);
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(8'h5A);

    // Word extremes and sync bytes inside the payload, good sum
    frame_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    {cur_first, cur_second, cur_first, cur_second},
                    32'h0123_4567, 32'h89AB_CDEF, 32'h0000_0001, 32'hFFFF_FFFE};
    send_frame(1'b0);

    // All ones with a wrong check byte
    foreach (frame_words[w]) frame_words[w] = 32'hFFFF_FFFF;
    send_frame(1'b1);

    // Random: sender idles 24/100, receiver 77/100
    run_block(220, 5);
    apply_syncs(8'h00, 8'hFF);
    run_block(220, 5);

    // Roles swapped
    apply_syncs(8'hFF, 8'h00);
    send_idle_pct = 77;
    recv_idle_pct = 24;
    run_block(220, 5);
    apply_syncs(8'hA5, 8'hA5);
    run_block(220, 5);

    // Full rate both sides
    apply_syncs(8'hFF, 8'hFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_block(220, 5);
    apply_syncs(8'($urandom), 8'($urandom));
    run_block(220, 5);

    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes under %0d sync settings (reset, extremes, equal, random).",
             bytes_sent, sync_settings);
    $display("Checked %0d frames, %0d of them with a checksum mismatch; %0d mismatches.",
             frames_checked, bad_sum_frames, errors);
    if (errors == 0) begin
      $display("sync_header_frame_parser_with_sum_check_top test passed");
    end else begin
      $display("sync_header_frame_parser_with_sum_check_top test failed");
    end
    $finish;
  end

endmodule
